### sv/gaussian_blur_3x3_rgba_macros.svh
// Assertion macros shared by the blur checker.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef GAUSSIAN_BLUR_3X3_RGBA_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_RGBA_MACROS_SVH

// Clocked check, switched off while reset is held.
`define GB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that must also hold during reset.
`define GB3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### sv/gb3_pkg.sv
// Shared types and constants for the 3x3 RGBA blur.
// No dependencies; used by every module of the block.
package gb3_pkg;

  localparam int unsigned CFG_W          = 12;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned NUM_CH         = 4;
  localparam int unsigned PIX_W          = CH_W * NUM_CH;
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 4095;
  localparam int unsigned RST_WIDTH      = 2048;
  localparam int unsigned RST_HEIGHT     = 2048;

  // corner and edge sums of four 8 bit values, full weighted sum up to 40 * 255
  localparam int unsigned GRP_W = 10;
  localparam int unsigned SUM_W = 14;

  // floor(x / 40) == (x * 52429) >> 21 for every x below 2^14
  localparam int unsigned    RECIP_W     = 16;
  localparam logic [15:0]    RECIP_40    = 16'd52429;
  localparam int unsigned    RECIP_SHIFT = 21;

  localparam int unsigned OFIFO_DEPTH = 8;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // per-item decisions handed from the control front end to the datapath
  typedef struct packed {
    logic has_res;    // item releases one output pixel
    logic last;       // that pixel closes the frame
    logic shift;      // window advances
    logic wr;         // line store is written back
    logic drain;      // frame complete: reuse the stored row as bottom row
    logic left_mid;   // left column replicates the centre column
    logic right_new;  // right column is the incoming column
    logic top_rep;    // top row replicates the centre row
    logic bot_rep;    // bottom row replicates the centre row
  } ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            frame_last;
  } res_t;

endpackage

### sv/gb3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. Depends on gb3_pkg for defaults.
module gb3_ram #(
  parameter  int unsigned WIDTH = 2 * gb3_pkg::PIX_W,
  parameter  int unsigned DEPTH = gb3_pkg::DEF_MAX_WIDTH,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gb3_ctrl.sv
// Front end: size registers, raster counters and per-beat decisions.
// Depends on gb3_pkg; drives the line store read and the datapath controls.
module gb3_ctrl #(
  parameter  int unsigned MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter  int unsigned MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned CW         = $clog2(MAX_WIDTH),
  localparam int unsigned RW         = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [gb3_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       mode_i,
  output logic                       take_o,
  output gb3_pkg::ctl_t              ctl_o,
  output logic [CW-1:0]              addr_o
);
  import gb3_pkg::*;

  localparam int unsigned WEW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int unsigned HEW = (CFG_W > RW) ? CFG_W : RW;
  localparam int unsigned WLAST_RST = ((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1;
  localparam int unsigned HLAST_RST =
      ((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT) - 1;

  logic [CW-1:0]  wlast_q, wlast_d;
  logic [RW-1:0]  hlast_q, hlast_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [WEW-1:0] wval;
  logic [HEW-1:0] hval;
  logic [CW-1:0]  col;
  logic [RW-1:0]  ctr_row;
  logic           drain, out_prev, out_cur, last;

  assign cfg_ready_o = 1'b1;

  // Keep the last valid column and row index; zero acts as one, oversize saturates.
  assign wval = WEW'(cfg_data_i);
  assign hval = HEW'(cfg_data_i);

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH: begin
          if (wval == '0) begin
            wlast_d = '0;
          end else if (wval > WEW'(MAX_WIDTH)) begin
            wlast_d = CW'(MAX_WIDTH - 1);
          end else begin
            wlast_d = CW'(wval - WEW'(1));
          end
        end
        REG_HEIGHT: begin
          if (hval == '0) begin
            hlast_d = '0;
          end else if (hval > HEW'(MAX_HEIGHT)) begin
            hlast_d = RW'(MAX_HEIGHT - 1);
          end else begin
            hlast_d = RW'(hval - HEW'(1));
          end
        end
      endcase
    end
  end

  // Per-beat decisions
  assign col      = (col_q > wlast_q) ? wlast_q : col_q;
  assign drain    = row_q > hlast_q;
  assign out_prev = (col == '0) && (row_q >= RW'(2));
  assign out_cur  = (col != '0) && (row_q != '0);
  assign last     = out_prev && (row_q > hlast_q + RW'(1));
  assign ctr_row  = out_prev ? row_q - RW'(2) : row_q - RW'(1);

  always_comb begin
    ctl_o.has_res   = out_prev || out_cur;
    ctl_o.last      = last;
    ctl_o.shift     = !last;
    ctl_o.wr        = !last && !drain;
    ctl_o.drain     = drain;
    ctl_o.left_mid  = out_prev ? (wlast_q == '0) : (col == CW'(1));
    ctl_o.right_new = !out_prev;
    ctl_o.top_rep   = ctr_row == '0;
    ctl_o.bot_rep   = ctr_row >= hlast_q;
  end

  // A flush beat before the frame is complete is dropped.
  assign take_o = in_valid_i && !in_stall_i && (drain || !mode_i);
  assign addr_o = col;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take_o) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col == wlast_q) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CW'(WLAST_RST);
      hlast_q <= RW'(HLAST_RST);
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

### sv/gb3_filter.sv
// Datapath: line store write-back with forwarding, 3x3 window, weighted sum, /40.
// Depends on gb3_pkg; sits behind gb3_ctrl and feeds gb3_ofifo.
module gb3_filter #(
  parameter  int unsigned MAX_WIDTH = gb3_pkg::DEF_MAX_WIDTH,
  localparam int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  gb3_pkg::ctl_t              ctl_i,
  input  logic [AW-1:0]              addr_i,
  input  gb3_pkg::pix_t              pix_i,
  input  logic [2*gb3_pkg::PIX_W-1:0] rdata_i,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [2*gb3_pkg::PIX_W-1:0] wdata_o,
  output logic                       push_o,
  output gb3_pkg::res_t              res_o
);
  import gb3_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // stage B: line store data returns
  logic            b_vld_q;
  ctl_t            b_ctl_q;
  logic [AW-1:0]   b_addr_q;
  pix_t            b_pix_q;
  logic            fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic [2*PIX_W-1:0] rd;
  pix_t            older, prev;
  pix_t            nc  [3];
  pix_t            lft [3];
  pix_t            rgt [3];
  pix_t            win_q [3][2];
  pix_t            top_l, top_m, top_r, mid_l, mid_r, ctr_px, bot_l, bot_m, bot_r;
  logic [GRP_W-1:0] corner_d [NUM_CH];
  logic [GRP_W-1:0] edge_d   [NUM_CH];

  // stage C: group sums
  logic             c_vld_q;
  logic             c_last_q;
  logic [GRP_W-1:0] corner_q [NUM_CH];
  logic [GRP_W-1:0] edge_q   [NUM_CH];
  logic [CH_W-1:0]  centre_q [NUM_CH];
  logic [SUM_W-1:0] sum_d    [NUM_CH];

  // stage D: weighted sums
  logic             d_vld_q;
  logic             d_last_q;
  logic [SUM_W-1:0] sum_q    [NUM_CH];
  logic [PROD_W-1:0] prod    [NUM_CH];

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      b_ctl_q  <= ctl_i;
      b_addr_q <= addr_i;
      b_pix_q  <= pix_i;
    end
    fwd_data_q <= wdata_o;
  end

  // The RAM returns stale data when the next beat reads the entry being written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      b_vld_q <= take_i;
      fwd_q   <= take_i && we_o && (addr_i == b_addr_q);
    end
  end

  assign rd    = fwd_q ? fwd_data_q : rdata_i;
  assign older = rd[PIX_W-1:0];
  assign prev  = rd[2*PIX_W-1:PIX_W];

  // entry layout: upper half the row above, lower half the row two above
  assign we_o    = b_vld_q && b_ctl_q.wr;
  assign waddr_o = b_addr_q;
  assign wdata_o = {b_pix_q, prev};

  assign nc[0] = older;
  assign nc[1] = prev;
  assign nc[2] = b_ctl_q.drain ? prev : b_pix_q;

  // column 0 is the older of the two held columns, column 1 the newer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (b_vld_q && b_ctl_q.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= nc[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lft[r] = b_ctl_q.left_mid  ? win_q[r][1] : win_q[r][0];
      rgt[r] = b_ctl_q.right_new ? nc[r]       : win_q[r][1];
    end
  end

  // replicate the centre row at the top and bottom borders
  assign top_l  = b_ctl_q.top_rep ? lft[1]      : lft[0];
  assign top_m  = b_ctl_q.top_rep ? win_q[1][1] : win_q[0][1];
  assign top_r  = b_ctl_q.top_rep ? rgt[1]      : rgt[0];
  assign bot_l  = b_ctl_q.bot_rep ? lft[1]      : lft[2];
  assign bot_m  = b_ctl_q.bot_rep ? win_q[1][1] : win_q[2][1];
  assign bot_r  = b_ctl_q.bot_rep ? rgt[1]      : rgt[2];
  assign mid_l  = lft[1];
  assign mid_r  = rgt[1];
  assign ctr_px = win_q[1][1];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      corner_d[ch] = GRP_W'(top_l[ch*CH_W +: CH_W]) + GRP_W'(top_r[ch*CH_W +: CH_W])
                   + GRP_W'(bot_l[ch*CH_W +: CH_W]) + GRP_W'(bot_r[ch*CH_W +: CH_W]);
      edge_d[ch]   = GRP_W'(top_m[ch*CH_W +: CH_W]) + GRP_W'(bot_m[ch*CH_W +: CH_W])
                   + GRP_W'(mid_l[ch*CH_W +: CH_W]) + GRP_W'(mid_r[ch*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    c_last_q <= b_ctl_q.last;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      corner_q[ch] <= corner_d[ch];
      edge_q[ch]   <= edge_d[ch];
      centre_q[ch] <= ctr_px[ch*CH_W +: CH_W];
    end
  end

  // weights 1, 4 and 20 (16 + 4)
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = SUM_W'(corner_q[ch]) + (SUM_W'(edge_q[ch]) << 2)
                + (SUM_W'(centre_q[ch]) << 4) + (SUM_W'(centre_q[ch]) << 2);
    end
  end

  always_ff @(posedge clk_i) begin
    d_last_q <= c_last_q;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_q[ch] <= sum_d[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q && b_ctl_q.has_res;
      d_vld_q <= c_vld_q;
    end
  end

  // divide by 40 through the reciprocal
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(sum_q[ch]) * PROD_W'(RECIP_40);
    end
  end

  assign push_o           = d_vld_q;
  assign res_o.red        = prod[0][RECIP_SHIFT +: CH_W];
  assign res_o.green      = prod[1][RECIP_SHIFT +: CH_W];
  assign res_o.blue       = prod[2][RECIP_SHIFT +: CH_W];
  assign res_o.alpha      = prod[3][RECIP_SHIFT +: CH_W];
  assign res_o.frame_last = d_last_q;

endmodule

### sv/gb3_ofifo.sv
// Credit-counted output queue: a taken beat with a result reserves a slot.
// Depends on gb3_pkg; decouples the datapath from the output stall.
module gb3_ofifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          resv_i,
  input  logic          push_i,
  input  gb3_pkg::res_t res_i,
  output logic          stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gb3_pkg::res_t res_o
);
  import gb3_pkg::*;

  localparam int unsigned PW   = $clog2(OFIFO_DEPTH);
  localparam int unsigned CNTW = $clog2(OFIFO_DEPTH + 1);

  res_t            mem_q [OFIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] cred_q, cred_d;
  logic            pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign res_o       = mem_q[rd_ptr_q];
  assign stall_o     = cred_q == CNTW'(OFIFO_DEPTH);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    cnt_d  = cnt_q + CNTW'(push_i) - CNTW'(pop);
    cred_d = cred_q + CNTW'(resv_i) - CNTW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      cred_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      cred_q   <= cred_d;
    end
  end

endmodule

### sv/gaussian_blur_3x3_rgba.sv
// Channel   Direction  Handshake          Beat
// in        sink       in_valid/in_stall  mode + RGBA8 pixel
// out       source     out_valid/out_stall  blurred RGBA8 + frame_last
// cfg       sink       cfg_valid/cfg_ready  register index + 12 bit data
//
// One input beat per cycle while in_stall is low; the line store has one read and
// one write port and is read-modify-written at one entry per beat, with forwarding
// on back-to-back hits. Results are registered in stages B, C and D, then queued.
// The output queue holds 8 beats; in_stall rises once 8 results are reserved.
// Reset clears counters, window and queue; the line store is not cleared.
module gaussian_blur_3x3_rgba #(
  parameter int unsigned MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [gb3_pkg::CH_W-1:0]  pixel_red_i,
  input  logic [gb3_pkg::CH_W-1:0]  pixel_green_i,
  input  logic [gb3_pkg::CH_W-1:0]  pixel_blue_i,
  input  logic [gb3_pkg::CH_W-1:0]  pixel_alpha_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gb3_pkg::CH_W-1:0]  out_red_o,
  output logic [gb3_pkg::CH_W-1:0]  out_green_o,
  output logic [gb3_pkg::CH_W-1:0]  out_blue_o,
  output logic [gb3_pkg::CH_W-1:0]  out_alpha_o,
  output logic                      frame_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [gb3_pkg::CFG_W-1:0] cfg_data_i
);
  import gb3_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic               take;
  ctl_t               ctl;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [2*PIX_W-1:0] wdata;
  logic [2*PIX_W-1:0] rdata;
  logic               push;
  res_t               res_in;
  res_t               res_out;
  pix_t               pix;

  assign pix = {pixel_alpha_i, pixel_blue_i, pixel_green_i, pixel_red_i};

  gb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .mode_i      (mode_i),
    .take_o      (take),
    .ctl_o       (ctl),
    .addr_o      (raddr)
  );

  gb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (take),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gb3_filter #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .ctl_i   (ctl),
    .addr_i  (raddr),
    .pix_i   (pix),
    .rdata_i (rdata),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .push_o  (push),
    .res_o   (res_in)
  );

  gb3_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .resv_i      (take && ctl.has_res),
    .push_i      (push),
    .res_i       (res_in),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign out_red_o    = res_out.red;
  assign out_green_o  = res_out.green;
  assign out_blue_o   = res_out.blue;
  assign out_alpha_o  = res_out.alpha;
  assign frame_last_o = res_out.frame_last;

endmodule

### sv/gb3_checker.sv
// Port-level checks for the blur block, attached to the top level by bind.
// Depends on gaussian_blur_3x3_rgba_macros.svh.
`include "gaussian_blur_3x3_rgba_macros.svh"

module gb3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic [7:0]  out_alpha_o,
  input logic        frame_last_o,
  input logic        cfg_ready_o
);

  logic [31:0] pend_q, pend_d;
  logic        in_acc, out_acc, out_held;
  logic [32:0] out_beat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_held = out_valid_o && out_stall_i;
  assign out_beat = {out_red_o, out_green_o, out_blue_o, out_alpha_o, frame_last_o};
  assign pend_d   = pend_q + 32'(in_acc) - 32'(out_acc);

  // beats taken minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `GB3_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_beat), "stalled beat changed")
  `GB3_ASSERT(a_out_after_in, out_acc |-> pend_q != 32'd0, "result without input")
  `GB3_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_held), "unexpected input stall")
  `GB3_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind gaussian_blur_3x3_rgba gb3_checker u_gb3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_red_o     (out_red_o),
  .out_green_o   (out_green_o),
  .out_blue_o    (out_blue_o),
  .out_alpha_o   (out_alpha_o),
  .frame_last_o  (frame_last_o),
  .cfg_ready_o   (cfg_ready_o)
);

### bench/tb_gaussian_blur_3x3_rgba.sv
// Self-checking bench for gaussian_blur_3x3_rgba: RGBA8 frames of varied size go in,
// and a cycle-free predictor of the 3x3 blur checks every output beat in order.
// Depends on gb3_pkg and the block itself.
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3_rgba;
  import gb3_pkg::*;

  class blur_scoreboard;
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    bit [PIX_W-1:0] prev_row [DEF_MAX_WIDTH];
    bit [PIX_W-1:0] older_row [DEF_MAX_WIDTH];
    bit [PIX_W-1:0] win [3][3];
    int unsigned    col;
    int unsigned    row;
    res_t           blurred_due [$];
    int             errors;

    function new();
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      col        = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [CFG_W-1:0] value);
      if (idx == REG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
      return height_reg;
    endfunction

    // Weighted 1 4 1 / 4 20 4 / 1 4 1 sum over 40; rows and columns pick window taps.
    function res_t blur_at(int unsigned rt, int unsigned rb, int unsigned cl,
                           int unsigned cm, int unsigned cr, bit last);
      int unsigned kern [3][3] = '{'{1, 4, 1}, '{4, 20, 4}, '{1, 4, 1}};
      int unsigned rsel [3];
      int unsigned csel [3];
      int unsigned sum;
      bit [CH_W-1:0] chan [NUM_CH];
      res_t px;
      rsel = '{rt, 1, rb};
      csel = '{cl, cm, cr};
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            sum += kern[i][j] * win[rsel[i]][csel[j]][CH_W*ch +: CH_W];
        chan[ch] = CH_W'(sum / 40);
      end
      px.red        = chan[0];
      px.green      = chan[1];
      px.blue       = chan[2];
      px.alpha      = chan[3];
      px.frame_last = last;
      return px;
    endfunction

    // pix packs red in the low byte and alpha in the high byte
    function void take_input(bit mode, bit [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned centre_row;
      int unsigned centre_col;
      bit drain;
      bit last;
      bit [PIX_W-1:0] upper;
      bit [PIX_W-1:0] middle;
      bit [PIX_W-1:0] cur;
      w = eff_width();
      h = eff_height();
      c = (col >= w) ? w - 1 : col;
      drain = (row >= h);
      // a flush before the frame is complete does nothing
      if (!drain && mode) return;

      // column 0 releases the last pixel of the row two back
      if (c == 0 && row >= 2) begin
        last = (row >= h + 1);
        centre_row = row - 2;
        blurred_due.push_back(blur_at(centre_row == 0 ? 1 : 0, centre_row >= h - 1 ? 1 : 2,
                                      w == 1 ? 2 : 1, 2, 2, last));
        if (last) begin
          col = 0;
          row = 0;
          return;
        end
      end

      upper  = older_row[c];
      middle = prev_row[c];
      if (drain) begin
        cur = middle;
      end else begin
        cur = pix;
        older_row[c] = middle;
        prev_row[c]  = pix;
      end
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper;
      win[1][2] = middle;
      win[2][2] = cur;

      if (c >= 1 && row >= 1) begin
        centre_row = row - 1;
        centre_col = c - 1;
        blurred_due.push_back(blur_at(centre_row == 0 ? 1 : 0, centre_row >= h - 1 ? 1 : 2,
                                      centre_col == 0 ? 1 : 0, 1,
                                      centre_col >= w - 1 ? 1 : 2, 1'b0));
      end

      if (c + 1 >= w) begin
        col = 0;
        row++;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_output(res_t got);
      res_t want;
      logic [CH_W-1:0] want_v [5];
      logic [CH_W-1:0] got_v [5];
      string field [5] = '{"red", "green", "blue", "alpha", "frame_last"};
      if (blurred_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %0h", $time, got);
        errors++;
        return;
      end
      want = blurred_due.pop_front();
      want_v = '{want.red, want.green, want.blue, want.alpha, {7'b0, want.frame_last}};
      got_v  = '{got.red, got.green, got.blue, got.alpha, {7'b0, got.frame_last}};
      for (int i = 0; i < 5; i++) begin
        if (got_v[i] !== want_v[i]) begin
          $display("%0t: %s expected %0h, got %0h", $time, field[i], want_v[i], got_v[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_mode = 1'b0;
  logic [CH_W-1:0] px_red = '0;
  logic [CH_W-1:0] px_green = '0;
  logic [CH_W-1:0] px_blue = '0;
  logic [CH_W-1:0] px_alpha = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CH_W-1:0] res_red;
  logic [CH_W-1:0] res_green;
  logic [CH_W-1:0] res_blue;
  logic [CH_W-1:0] res_alpha;
  logic            res_last;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_reg_e        cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  blur_scoreboard blur_sb;
  int unsigned    burst_left = 0;
  int unsigned    random_beats = 0;
  int unsigned    stall_style = 0;
  int unsigned    stall_left = 0;
  bit [3:0]       stall_tick = '0;

  gaussian_blur_3x3_rgba uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (in_mode),
    .pixel_red_i   (px_red),
    .pixel_green_i (px_green),
    .pixel_blue_i  (px_blue),
    .pixel_alpha_i (px_alpha),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_red_o     (res_red),
    .out_green_o   (res_green),
    .out_blue_o    (res_blue),
    .out_alpha_o   (res_alpha),
    .frame_last_o  (res_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check each output beat, then pick the next stall from the current style.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      blur_sb.check_output('{red: res_red, green: res_green, blue: res_blue,
                             alpha: res_alpha, frame_last: res_last});
    end
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_tick[2];
    endcase
  end

  function automatic bit [PIX_W-1:0] random_pixel();
    bit [PIX_W-1:0] pix;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(0, 7))
        0: pix[CH_W*ch +: CH_W] = '0;
        1: pix[CH_W*ch +: CH_W] = '1;
        default: pix[CH_W*ch +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return pix;
  endfunction

  task automatic write_reg(cfg_reg_e idx, bit [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    blur_sb.set_reg(idx, value);
  endtask

  task automatic set_frame_size(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Send one beat; bursts of random length with random gaps between them.
  task automatic offer_beat(bit mode, bit [PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    px_red   <= pix[7:0];
    px_green <= pix[15:8];
    px_blue  <= pix[23:16];
    px_alpha <= pix[31:24];
    do @(posedge clk_i); while (in_stall);
    blur_sb.take_input(mode, pix);
    burst_left--;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (blur_sb.blurred_due.size() != 0);
    burst_left = 0;
  endtask

  // Drain, then allow for the pipeline before touching the registers.
  task automatic finish_phase();
    hold_until_drained();
    repeat (8) @(posedge clk_i);
  endtask

  // One whole frame at the current size, with stray flushes mid-frame and
  // the odd pixel beat among the flushes that close it.
  task automatic run_frame(bit pause_mid);
    int unsigned w;
    int unsigned h;
    int unsigned n_px;
    w = blur_sb.eff_width();
    h = blur_sb.eff_height();
    n_px = w * h;
    for (int unsigned k = 0; k < n_px; k++) begin
      if (pause_mid && k == n_px / 2) hold_until_drained();
      if ($urandom_range(0, 15) == 0) offer_beat(1'b1, random_pixel());
      offer_beat(1'b0, random_pixel());
      random_beats++;
    end
    for (int unsigned k = 0; k <= w; k++) begin
      offer_beat($urandom_range(0, 3) != 0, random_pixel());
      random_beats++;
    end
  endtask

  initial begin
    bit [PIX_W-1:0] corner_px [9];
    bit [CFG_W-1:0] w;
    bit [CFG_W-1:0] h;
    blur_sb = new();
    corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h00FF_00FF, 32'hFF00_FF00, 32'h0102_0304, 32'hFEFD_FCFB,
                  32'h80FF_7F00};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame of extreme pixels, a stray flush, a full drain mid-frame
    // and a pixel beat among the closing flushes
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 2) offer_beat(1'b1, 32'hFFFF_FFFF);
      if (i == 5) hold_until_drained();
      offer_beat(1'b0, corner_px[i]);
    end
    offer_beat(1'b1, 32'h0);
    offer_beat(1'b0, 32'hDEAD_BEEF);
    offer_beat(1'b1, 32'h0);
    offer_beat(1'b1, 32'h0);

    // single pixel frame
    finish_phase();
    set_frame_size(1, 1);
    offer_beat(1'b0, 32'hFFFF_FFFF);
    offer_beat(1'b1, 32'h0);
    offer_beat(1'b0, 32'h1234_5678);

    // register extremes: zero acts as one
    finish_phase();
    set_frame_size(0, 0);
    run_frame(1'b0);
    run_frame(1'b0);
    finish_phase();
    set_frame_size(40, 0);
    run_frame(1'b0);
    finish_phase();
    set_frame_size(0, 40);
    run_frame(1'b0);

    while (random_beats < 1650) begin
      case ($urandom_range(0, 9))
        0: w = CFG_W'($urandom_range(13, 80));
        default: w = CFG_W'($urandom_range(0, 12));
      endcase
      h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(10, 24))
                                      : CFG_W'($urandom_range(0, 9));
      finish_phase();
      set_frame_size(w, h);
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 5) == 0);
    end

    finish_phase();
    repeat (16) @(posedge clk_i);
    if (blur_sb.errors == 0 && blur_sb.blurred_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
